[rtl/limit_order_book_matcher_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the order book matcher checker.
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define LOBM_ASSERT_NOW(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("order book matcher check failed");

// A condition that must hold in the cycle after its trigger.
`define LOBM_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("order book matcher check failed");

`endif

[rtl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and constants shared by the order book matcher and its checker.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int ORDER_SLOTS  = 1024;
  localparam int PRICE_LEVELS = 4096;
  localparam int MAX_FILLS    = 32;
  localparam int ID_W         = 10;
  localparam int PRICE_W      = 12;
  localparam int QTY_W        = 16;
  localparam int CLIENT_W     = 16;
  localparam int LINK_W       = ID_W + 1;
  localparam int LVL_W        = PRICE_W + 1;
  localparam int FILL_W       = $clog2(MAX_FILLS + 1);

  localparam logic [LINK_W-1:0] NONE_ID = LINK_W'(ORDER_SLOTS);

  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_MATCH  = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [CLIENT_W-1:0] client_ident;
    logic [ID_W-1:0]     order_ident;
    logic                order_side;
    logic [PRICE_W-1:0]  limit_price;
    logic [QTY_W-1:0]    order_quantity;
  } req_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] resp_client;
    logic [ID_W-1:0]     resp_order;
    logic [1:0]          resp_kind;
    logic                resp_status;
    logic [PRICE_W-1:0]  fill_price;
    logic [QTY_W-1:0]    fill_qty;
    logic                still_crossed;
    logic                last_result;
  } resp_t;

  typedef struct packed {
    logic                valid;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [CLIENT_W-1:0] client;
  } info_t;

  typedef struct packed {
    logic [QTY_W-1:0] initial_qty;
    logic [QTY_W-1:0] remaining;
  } qty_t;

endpackage

[rtl/limit_order_book_matcher.sv]
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Two-sided limit order book with price-time priority matching.
// ----------------------------------------------------------------------------
// After reset the block sweeps its level memories and order table, one
// level entry (head and tail) per cycle with the table alongside, and takes
// no request during that time. Requests are then handled one at a time by a
// sequencer around single-port synchronous memories. A new order on a busy
// slot or an in-place modify only sends its response; a new order also
// links the order at the tail of its level, a cancel unlinks it, and a
// requeueing modify does both. A removal that empties the best level adds
// a rescan that reads the head of each level in turn, toward worse prices.
// A match request handles one fill after another, each followed by the
// removal of any filled order and any rescan, and then sends a final
// response. Each response is held in an output register; the sequencer waits
// only when a new response is ready while the previous one is still stalled.
module limit_order_book_matcher
  import lobm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req_data,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output resp_t rsp_data
);

  typedef enum logic [19:0] {
    S_CLEAR   = 20'h00001,
    S_IDLE    = 20'h00002,
    S_DISP    = 20'h00004,
    S_MOD_ADD = 20'h00008,
    S_EMIT    = 20'h00010,
    S_RM_RD   = 20'h00020,
    S_RM_WR   = 20'h00040,
    S_RS_RD   = 20'h00080,
    S_RS_CHK  = 20'h00100,
    S_LT_RD   = 20'h00200,
    S_LT_WR   = 20'h00400,
    S_LT_WR2  = 20'h00800,
    S_M_CHK   = 20'h01000,
    S_M_HB    = 20'h02000,
    S_M_HA    = 20'h04000,
    S_M_IB    = 20'h08000,
    S_M_IA    = 20'h10000,
    S_M_FB    = 20'h20000,
    S_M_WB    = 20'h40000,
    S_M_RA    = 20'h80000
  } state_t;

  localparam int LVL_N = 2 * PRICE_LEVELS;
  localparam logic [LVL_W-1:0] CLR_LAST = LVL_W'(LVL_N - 1);

  // Memories: order table, quantities, queue links and level ends.
  info_t             info_mem [ORDER_SLOTS];
  qty_t              qty_mem  [ORDER_SLOTS];
  logic [LINK_W-1:0] prev_mem [ORDER_SLOTS];
  logic [LINK_W-1:0] next_mem [ORDER_SLOTS];
  logic [LINK_W-1:0] head_mem [LVL_N];
  logic [LINK_W-1:0] tail_mem [LVL_N];

  logic info_re, qty_re, prev_re, next_re, head_re, tail_re;
  logic info_we, qty_we, prev_we, next_we, head_we, tail_we;
  logic [ID_W-1:0] info_ra, qty_ra, link_ra, info_wa, qty_wa, prev_wa, next_wa;
  logic [LVL_W-1:0] lvl_ra, head_wa, tail_wa;
  info_t info_wd, info_q;
  qty_t  qty_wd, qty_q;
  logic [LINK_W-1:0] prev_wd, next_wd, head_wd, tail_wd;
  logic [LINK_W-1:0] prev_q, next_q, head_q, tail_q;

  // Sequencer registers.
  state_t state, emit_ret, rm_ret, lt_ret;
  logic [LVL_W-1:0] clr_idx;
  logic [ID_W-1:0] counter, cur_id, rm_id, lt_id, b_id, a_id;
  req_t req;
  logic lt_side, rs_side;
  logic [PRICE_W-1:0] lt_price, rs_p;
  logic [1:0] best_none;
  logic [PRICE_W-1:0] best_price [2];
  resp_t emit, pend;
  logic pend_v;
  logic [FILL_W-1:0] fills;
  logic [CLIENT_W-1:0] b_client;
  logic [PRICE_W-1:0] b_price;
  logic [QTY_W-1:0] b_init, b_rem, a_rem, fq;

  // Shared decisions.
  logic accept, crossed, cont, differ, rm_empty, rm_rescan, lt_better, rsp_load;
  logic [QTY_W-1:0] f_c;
  info_t new_info;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign crossed   = !best_none[0] && !best_none[1] && (best_price[0] >= best_price[1]);
  assign cont      = (fills < FILL_W'(MAX_FILLS)) && crossed;
  assign differ    = (req.limit_price != info_q.price) ||
                     (req.order_quantity != qty_q.initial_qty) ||
                     (req.order_side != info_q.side);
  assign rm_empty  = (prev_q == NONE_ID) && (next_q == NONE_ID);
  assign rm_rescan = rm_empty && !best_none[info_q.side] &&
                     (best_price[info_q.side] == info_q.price);
  assign lt_better = best_none[lt_side] ||
                     ((lt_side == SIDE_BID) ? (lt_price > best_price[lt_side])
                                            : (lt_price < best_price[lt_side]));
  assign f_c       = (b_rem < qty_q.remaining) ? b_rem : qty_q.remaining;
  assign new_info  = '{valid: 1'b1, side: req.order_side, price: req.limit_price,
                       client: req.client_ident};
  // The output register loads when it is empty or its response is taken.
  assign rsp_load  = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  // Memory port control for each sequencer step.
  always_comb begin
    info_re = 1'b0; qty_re = 1'b0; prev_re = 1'b0; next_re = 1'b0;
    head_re = 1'b0; tail_re = 1'b0;
    info_we = 1'b0; qty_we = 1'b0; prev_we = 1'b0; next_we = 1'b0;
    head_we = 1'b0; tail_we = 1'b0;
    info_ra = rm_id; qty_ra = rm_id; link_ra = rm_id; lvl_ra = {lt_side, lt_price};
    info_wa = cur_id; qty_wa = cur_id; prev_wa = lt_id; next_wa = lt_id;
    head_wa = {lt_side, lt_price}; tail_wa = {lt_side, lt_price};
    info_wd = new_info;
    qty_wd  = '{initial_qty: req.order_quantity, remaining: req.order_quantity};
    prev_wd = tail_q; next_wd = NONE_ID;
    head_wd = {1'b0, lt_id}; tail_wd = {1'b0, lt_id};
    unique case (state)
      S_CLEAR: begin
        head_we = 1'b1; tail_we = 1'b1;
        head_wa = clr_idx; tail_wa = clr_idx;
        head_wd = NONE_ID; tail_wd = NONE_ID;
        info_we = (clr_idx < LVL_W'(ORDER_SLOTS));
        info_wa = clr_idx[ID_W-1:0];
        info_wd = '0;
      end
      S_IDLE: begin
        info_re = accept; qty_re = accept;
        info_ra = (req_data.req_type == KIND_NEW) ? counter : req_data.order_ident;
        qty_ra  = info_ra;
      end
      S_DISP: begin
        if (req.req_type == KIND_NEW) begin
          info_we = !info_q.valid; qty_we = !info_q.valid;
        end else if (req.req_type == KIND_MODIFY && info_q.valid && !differ) begin
          info_we = 1'b1; qty_we = 1'b1;
          info_wd = '{valid: 1'b1, side: info_q.side, price: info_q.price,
                      client: req.client_ident};
        end
      end
      S_MOD_ADD: begin
        info_we = 1'b1; qty_we = 1'b1;
      end
      S_EMIT: ;
      S_RM_RD: begin
        info_re = 1'b1; prev_re = 1'b1; next_re = 1'b1;
      end
      S_RM_WR: begin
        head_wa = {info_q.side, info_q.price}; tail_wa = head_wa;
        if (prev_q == NONE_ID) begin
          head_we = 1'b1; head_wd = next_q;
        end else begin
          next_we = 1'b1; next_wa = prev_q[ID_W-1:0]; next_wd = next_q;
        end
        if (next_q == NONE_ID) begin
          tail_we = 1'b1; tail_wd = prev_q;
        end else begin
          prev_we = 1'b1; prev_wa = next_q[ID_W-1:0]; prev_wd = prev_q;
        end
        info_we = 1'b1; info_wa = rm_id;
        info_wd = '{valid: 1'b0, side: info_q.side, price: info_q.price,
                    client: info_q.client};
      end
      S_RS_RD: begin
        head_re = 1'b1; lvl_ra = {rs_side, rs_p};
      end
      S_RS_CHK: ;
      S_LT_RD: begin
        head_re = 1'b1; tail_re = 1'b1;
      end
      S_LT_WR: begin
        prev_we = 1'b1; next_we = 1'b1; tail_we = 1'b1;
        head_we = (head_q == NONE_ID);
      end
      S_LT_WR2: begin
        next_we = 1'b1; next_wa = tail_q[ID_W-1:0]; next_wd = {1'b0, lt_id};
      end
      S_M_CHK: ;
      S_M_HB: begin
        head_re = 1'b1; lvl_ra = {SIDE_BID, best_price[0]};
      end
      S_M_HA: begin
        head_re = 1'b1; lvl_ra = {SIDE_ASK, best_price[1]};
      end
      S_M_IB: begin
        info_re = 1'b1; qty_re = 1'b1; info_ra = b_id; qty_ra = b_id;
      end
      S_M_IA: begin
        info_re = 1'b1; qty_re = 1'b1; info_ra = a_id; qty_ra = a_id;
      end
      S_M_FB: begin
        qty_we = 1'b1; qty_wa = a_id;
        qty_wd = '{initial_qty: qty_q.initial_qty, remaining: qty_q.remaining - f_c};
      end
      S_M_WB: begin
        qty_we = 1'b1; qty_wa = b_id;
        qty_wd = '{initial_qty: b_init, remaining: b_rem - fq};
      end
      S_M_RA: ;
      default: ;
    endcase
  end

  // Synchronous memory ports with registered read data.
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (info_re) info_q <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (qty_we) qty_mem[qty_wa] <= qty_wd;
    if (qty_re) qty_q <= qty_mem[qty_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_q <= prev_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_q <= next_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_q <= head_mem[lvl_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_q <= tail_mem[lvl_ra];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      counter   <= '0;
      best_none <= 2'b11;
      rsp_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            req <= req_data;
            if (req_data.req_type == KIND_NEW) begin
              cur_id  <= counter;
              counter <= (counter == ID_W'(ORDER_SLOTS - 1)) ? '0 : counter + 1'b1;
            end else begin
              cur_id <= req_data.order_ident;
            end
            if (req_data.req_type == KIND_MATCH) begin
              fills  <= '0;
              pend_v <= 1'b0;
              state  <= S_M_CHK;
            end else begin
              state <= S_DISP;
            end
          end
        end
        S_DISP: begin
          // A new order fails on a busy slot, any other request on an unknown id.
          emit  <= '{resp_client: req.client_ident, resp_order: cur_id,
                     resp_kind: req.req_type,
                     resp_status: (info_q.valid == (req.req_type == KIND_NEW)) ?
                                  STATUS_FAIL : STATUS_OK,
                     fill_price: '0, fill_qty: '0, still_crossed: 1'b0,
                     last_result: 1'b1};
          state <= S_EMIT;
          if (req.req_type == KIND_NEW) begin
            lt_id    <= cur_id;
            lt_side  <= req.order_side;
            lt_price <= req.limit_price;
            lt_ret   <= S_IDLE;
            emit_ret <= info_q.valid ? S_IDLE : S_LT_RD;
          end else if (!info_q.valid) begin
            emit_ret <= S_IDLE;
          end else if (req.req_type == KIND_CANCEL) begin
            rm_id    <= cur_id;
            rm_ret   <= S_IDLE;
            emit_ret <= S_RM_RD;
          end else if (differ) begin
            rm_id    <= cur_id;
            rm_ret   <= S_MOD_ADD;
            emit_ret <= S_RM_RD;
          end else begin
            emit_ret <= S_IDLE;
          end
        end
        S_MOD_ADD: begin
          lt_id    <= cur_id;
          lt_side  <= req.order_side;
          lt_price <= req.limit_price;
          lt_ret   <= S_IDLE;
          state    <= S_LT_RD;
        end
        S_EMIT: begin
          if (rsp_load) begin
            rsp_data <= emit;
            state    <= emit_ret;
          end
        end
        S_RM_RD: state <= S_RM_WR;
        S_RM_WR: begin
          if (rm_rescan) begin
            best_none[info_q.side] <= 1'b1;
            rs_side <= info_q.side;
            rs_p    <= info_q.price;
            state   <= S_RS_RD;
          end else begin
            state <= rm_ret;
          end
        end
        S_RS_RD: state <= S_RS_CHK;
        S_RS_CHK: begin
          if (head_q != NONE_ID) begin
            best_none[rs_side]  <= 1'b0;
            best_price[rs_side] <= rs_p;
            state <= rm_ret;
          end else if (rs_side == SIDE_BID) begin
            if (rs_p == '0) state <= rm_ret;
            else begin
              rs_p  <= rs_p - 1'b1;
              state <= S_RS_RD;
            end
          end else begin
            if (rs_p == PRICE_W'(PRICE_LEVELS - 1)) state <= rm_ret;
            else begin
              rs_p  <= rs_p + 1'b1;
              state <= S_RS_RD;
            end
          end
        end
        S_LT_RD: state <= S_LT_WR;
        S_LT_WR: begin
          if (lt_better) begin
            best_none[lt_side]  <= 1'b0;
            best_price[lt_side] <= lt_price;
          end
          state <= (head_q == NONE_ID) ? lt_ret : S_LT_WR2;
        end
        S_LT_WR2: state <= lt_ret;
        S_M_CHK: begin
          if (cont) begin
            if (pend_v) begin
              emit     <= pend;
              pend_v   <= 1'b0;
              emit_ret <= S_M_HB;
              state    <= S_EMIT;
            end else begin
              state <= S_M_HB;
            end
          end else begin
            emit_ret <= S_IDLE;
            state    <= S_EMIT;
            pend_v   <= 1'b0;
            if (fills == '0) begin
              emit <= '{resp_client: req.client_ident, resp_order: req.order_ident,
                        resp_kind: KIND_MATCH, resp_status: STATUS_FAIL,
                        fill_price: '0, fill_qty: '0, still_crossed: 1'b0,
                        last_result: 1'b1};
            end else begin
              emit <= '{resp_client: pend.resp_client, resp_order: pend.resp_order,
                        resp_kind: pend.resp_kind, resp_status: pend.resp_status,
                        fill_price: pend.fill_price, fill_qty: pend.fill_qty,
                        still_crossed: crossed, last_result: 1'b1};
            end
          end
        end
        S_M_HB: state <= S_M_HA;
        S_M_HA: begin
          b_id  <= head_q[ID_W-1:0];
          state <= S_M_IB;
        end
        S_M_IB: begin
          a_id  <= head_q[ID_W-1:0];
          state <= S_M_IA;
        end
        S_M_IA: begin
          b_client <= info_q.client;
          b_price  <= info_q.price;
          b_init   <= qty_q.initial_qty;
          b_rem    <= qty_q.remaining;
          state    <= S_M_FB;
        end
        S_M_FB: begin
          fq    <= f_c;
          a_rem <= qty_q.remaining;
          emit  <= '{resp_client: b_client, resp_order: b_id, resp_kind: KIND_MATCH,
                     resp_status: STATUS_OK, fill_price: b_price, fill_qty: f_c,
                     still_crossed: 1'b0, last_result: 1'b0};
          pend  <= '{resp_client: info_q.client, resp_order: a_id,
                     resp_kind: KIND_MATCH, resp_status: STATUS_OK,
                     fill_price: info_q.price, fill_qty: f_c,
                     still_crossed: 1'b0, last_result: 1'b0};
          emit_ret <= S_M_WB;
          state    <= S_EMIT;
        end
        S_M_WB: begin
          fills  <= fills + 1'b1;
          pend_v <= 1'b1;
          if (b_rem == fq) begin
            rm_id  <= b_id;
            rm_ret <= S_M_RA;
            state  <= S_RM_RD;
          end else begin
            state <= S_M_RA;
          end
        end
        S_M_RA: begin
          if (a_rem == fq) begin
            rm_id  <= a_id;
            rm_ret <= S_M_CHK;
            state  <= S_RM_RD;
          end else begin
            state <= S_M_CHK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lobm_checker.sv]
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on the order book matcher, bound to its top level.
// ----------------------------------------------------------------------------
`include "limit_order_book_matcher_defines.svh"

module lobm_checker
  import lobm_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  req_valid,
  input logic  req_stall,
  input req_t  req_data,
  input logic  rsp_valid,
  input logic  rsp_stall,
  input resp_t rsp_data
);

  logic req_taken;
  logic rsp_crossed, rsp_final_fill, rsp_other, rsp_plain;
  assign req_taken = req_valid && !req_stall && (req_data.req_type == req_data.req_type);

  // Response classes used by the checks below.
  assign rsp_crossed    = rsp_valid && rsp_data.still_crossed;
  assign rsp_final_fill = rsp_data.last_result && (rsp_data.resp_kind == KIND_MATCH) &&
                          (rsp_data.resp_status == STATUS_OK);
  assign rsp_other      = rsp_valid && (rsp_data.resp_kind != KIND_MATCH);
  assign rsp_plain      = rsp_data.last_result && (rsp_data.fill_qty == '0);

  // A held response keeps its value until it is taken.
  `LOBM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

  // The block works on one request at a time.
  `LOBM_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_taken, req_stall)

  // The still-crossed flag only marks the final fill of a match.
  `LOBM_ASSERT_NOW(a_crossed_last, clk, rst, rsp_crossed, rsp_final_fill)

  // Any response to a request other than a match is a single, final response without a fill.
  `LOBM_ASSERT_NOW(a_single_resp, clk, rst, rsp_other, rsp_plain)

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
